FILE: sv/tmcr_pkg.sv
// Shared constants, command and status types for the text-mode cell renderer.
// No dependencies; imported by the controller, the datapath and the top level.
package tmcr_pkg;

	localparam int TEXT_COLUMNS     = 80;
	localparam int TEXT_BYTES       = 4000;
	localparam int GLYPH_HEIGHT     = 16;
	localparam int CURSOR_FIRST_ROW = 14;

	localparam int ADDR_W    = 12;
	localparam int BYTE_W    = 8;
	localparam int ROW_W     = 4;
	localparam int CELL_W    = ADDR_W - 1;
	localparam int COL_W     = 7;
	localparam int CUR_LN_W  = 5;
	localparam int COLOR_W   = 4;
	localparam int PX_W      = 10;
	localparam int PY_W      = 9;
	localparam int FONT_DEPTH = 1 << ADDR_W;
	localparam int TEXT_ROWS  = 1 << CELL_W;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RENDER_SUPPRESSED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COLUMN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_LINE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PHASE       = 3'd4;

	localparam logic REQ_TEXT_WRITE = 1'b0;
	localparam logic REQ_FONT_LOAD  = 1'b1;

	localparam int DIV_SHIFT = 20;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam logic [RECIP_W-1:0] COL_RECIP = RECIP_W'((1 << DIV_SHIFT) / TEXT_COLUMNS);
	localparam int PROD_W    = 32;

	typedef struct packed {
		logic              accept;
		logic              clr_we;
		logic [ADDR_W-1:0] clr_addr;
		logic              txt_rd;
		logic              cell_ld;
		logic              font_rd;
		logic [ROW_W-1:0]  row;
	} tmcr_cmd_t;

	typedef struct packed {
		logic render;
		logic s1_busy;
		logic pipe_free;
	} tmcr_sts_t;

endpackage

FILE: sv/tmcr_ctrl.sv
// Controller state machine: clearing pass, item acceptance and glyph row sequencing.
// Depends on tmcr_pkg; drives commands into tmcr_dp and reads its status.
module tmcr_ctrl
	import tmcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  tmcr_sts_t sts,
	output tmcr_cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_TEXT  = 3'd2;
	localparam logic [2:0] ST_CELL  = 3'd3;
	localparam logic [2:0] ST_ROWS  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic              accept;
	logic              issue;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tready && s_tvalid;
	assign issue    = (state_q == ST_ROWS) && sts.pipe_free;

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.clr_we   = (state_q == ST_CLEAR);
		cmd.clr_addr = clr_cnt_q;
		cmd.txt_rd   = (state_q == ST_TEXT);
		cmd.cell_ld  = (state_q == ST_CELL);
		cmd.font_rd  = issue;
		cmd.row      = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			row_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(FONT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && sts.render) begin
						state_q <= ST_TEXT;
					end
				end
				ST_TEXT: begin
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					row_q   <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (issue) begin
						row_q <= row_q + 1'b1;
						if (row_q == ROW_W'(GLYPH_HEIGHT - 1)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!sts.s1_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/tmcr_dp.sv
// Datapath: configuration registers, text and font memories, cell position divider,
// font read stage and output register. Depends on tmcr_pkg; driven by tmcr_ctrl.
module tmcr_dp
	import tmcr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  tmcr_cmd_t               cmd,
	output tmcr_sts_t               sts,
	input  logic [IN_DATA_W-1:0]    s_tdata,
	input  logic                    s_tuser,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    m_tready,
	output logic                    m_tvalid,
	output logic [OUT_DATA_W-1:0]   m_tdata,
	output logic                    m_tlast
);

	logic                  video_mode_q;
	logic                  render_suppressed_q;
	logic [COL_W-1:0]      cursor_column_q;
	logic [CUR_LN_W-1:0]   cursor_line_q;
	logic                  flash_phase_q;

	logic [2*BYTE_W-1:0]   txt_mem [TEXT_ROWS];
	logic [BYTE_W-1:0]     font_mem [FONT_DEPTH];
	logic [2*BYTE_W-1:0]   txt_rd_q;

	logic [ADDR_W-1:0]     in_addr;
	logic [BYTE_W-1:0]     in_data;
	logic [BYTE_W-1:0]     in_code;
	logic [ROW_W-1:0]      in_gline;

	logic [CELL_W-1:0]     cell_q;
	logic [CELL_W-1:0]     line_est_q;
	logic [CELL_W-1:0]     line_q;
	logic [COL_W-1:0]      col_q;
	logic [PROD_W-1:0]     prod;
	logic [CELL_W-1:0]     rem0;
	logic [CELL_W-1:0]     rem;
	logic [CELL_W-1:0]     line_fix;

	logic                  rd_v_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [BYTE_W-1:0]     font_rd_s1;
	logic                  load_out;
	logic                  inv;
	logic [3:0]            fg;
	logic [3:0]            bg;
	logic [8*COLOR_W-1:0]  colors;

	logic                  out_v_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	assign in_addr  = s_tdata[11:0];
	assign in_data  = s_tdata[19:12];
	assign in_code  = s_tdata[27:20];
	assign in_gline = s_tdata[31:28];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_mode_q        <= 1'b0;
			render_suppressed_q <= 1'b0;
			cursor_column_q     <= '0;
			cursor_line_q       <= '0;
			flash_phase_q       <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_VIDEO_MODE:        video_mode_q        <= cfg_data[0];
				CFG_RENDER_SUPPRESSED: render_suppressed_q <= cfg_data[0];
				CFG_CURSOR_COLUMN:     cursor_column_q     <= cfg_data[COL_W-1:0];
				CFG_CURSOR_LINE:       cursor_line_q       <= cfg_data[CUR_LN_W-1:0];
				CFG_FLASH_PHASE:       flash_phase_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sts.render = (s_tuser == REQ_TEXT_WRITE) && !video_mode_q && !render_suppressed_q
		&& ({1'b0, in_addr} < 13'(TEXT_BYTES));

	// text memory: one cell per row, character in the low lane, attribute in the high lane
	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			txt_mem[cmd.clr_addr[CELL_W-1:0]] <= '0;
		end else if (cmd.accept && s_tuser == REQ_TEXT_WRITE) begin
			if (in_addr[0]) begin
				txt_mem[in_addr[ADDR_W-1:1]][2*BYTE_W-1:BYTE_W] <= in_data;
			end else begin
				txt_mem[in_addr[ADDR_W-1:1]][BYTE_W-1:0] <= in_data;
			end
		end
		if (cmd.txt_rd) begin
			txt_rd_q <= txt_mem[cell_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			font_mem[cmd.clr_addr] <= '0;
		end else if (cmd.accept && s_tuser == REQ_FONT_LOAD) begin
			font_mem[{in_code, in_gline}] <= in_data;
		end
		if (cmd.font_rd) begin
			font_rd_s1 <= font_mem[{txt_rd_q[BYTE_W-1:0], cmd.row}];
		end
	end

	assign prod     = PROD_W'(cell_q) * PROD_W'(COL_RECIP);
	assign rem0     = cell_q - CELL_W'(line_est_q * CELL_W'(TEXT_COLUMNS));
	assign rem      = (rem0 >= CELL_W'(TEXT_COLUMNS)) ? rem0 - CELL_W'(TEXT_COLUMNS) : rem0;
	assign line_fix = (rem0 >= CELL_W'(TEXT_COLUMNS)) ? line_est_q + 1'b1 : line_est_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cell_q <= in_addr[ADDR_W-1:1];
		end
		if (cmd.txt_rd) begin
			line_est_q <= prod[DIV_SHIFT +: CELL_W];
		end
		if (cmd.cell_ld) begin
			col_q  <= rem[COL_W-1:0];
			line_q <= line_fix;
		end
		if (cmd.font_rd) begin
			row_s1 <= cmd.row;
		end
	end

	assign load_out      = rd_v_s1 && (!out_v_q || m_tready);
	assign sts.s1_busy   = rd_v_s1;
	assign sts.pipe_free = !rd_v_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.font_rd) begin
				rd_v_s1 <= 1'b1;
			end else if (load_out) begin
				rd_v_s1 <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign fg  = txt_rd_q[BYTE_W +: 4];
	assign bg  = txt_rd_q[2*BYTE_W-1 -: 4];
	assign inv = flash_phase_q && (col_q == cursor_column_q)
		&& (line_q == CELL_W'(cursor_line_q)) && (row_s1 >= ROW_W'(CURSOR_FIRST_ROW));

	always_comb begin
		for (int x = 0; x < 8; x++) begin
			colors[x*COLOR_W +: COLOR_W] = (font_rd_s1[7-x] ^ inv) ? fg[COLOR_W-1:0]
				: bg[COLOR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {5'b0, colors,
				PY_W'({line_q, 5'b0}) + PY_W'({row_s1, 1'b0}),
				PX_W'({col_q, 4'b0})};
			out_last_q <= (row_s1 == ROW_W'(GLYPH_HEIGHT - 1));
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: sv/text_mode_cell_renderer_unit.sv
// Text-mode cell renderer: a write to a visible cell yields GLYPH_HEIGHT (16) glyph rows.
// Stages: cell index, text read and line estimate, cell position, font row read and output
// register; then one row per cycle while m_tready allows, set by the single font memory
// read port. Font loads and writes that render nothing are taken without leaving idle.
// Reset (arst_n, asynchronous): clears registers, then a clearing pass zeroes both
// memories while s_tready stays low; configuration writes are taken throughout.
module text_mode_cell_renderer_unit
	import tmcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// byte_address[11:0], data_byte[19:12], glyph_code[27:20], glyph_line[31:28]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_x[9:0], pixel_y[18:10], color_0..color_7[50:19] four bits each, zero[55:51]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// last_row
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tmcr_cmd_t cmd;
	tmcr_sts_t sts;

	assign cfg_ready = 1'b1;

	tmcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmcr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.clr_we, cmd.txt_rd, cmd.cell_ld, cmd.font_rd}))
		else $error("controller issued overlapping commands");

	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !sts.s1_busy)
		else $error("new transaction taken while a font row is still in flight");

	assert property (@(posedge clk) disable iff (!arst_n) cmd.clr_we |-> !s_tready)
		else $error("transaction taken during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n) cmd.txt_rd |=> cmd.cell_ld)
		else $error("cell position not loaded after text read");

endmodule
